// File: rtl/afdt_pkg.sv
package afdt_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TS_W       = 64;
  localparam int unsigned DUR_W      = 17;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned PSKIP_W    = 16;
  localparam int unsigned CIDX_W     = 2;
  localparam int unsigned OPUS_LEN_W = 12;
  localparam int unsigned OPUS_D_W   = 18;
  localparam int unsigned FLAC_LEN_W = 16;
  localparam int unsigned TRIM_W     = 13;
  localparam int unsigned OBUF_DEPTH = 2;

  localparam logic [BYTE_W-1:0] FLAC_SYNC = 8'hFF;

  // byte positions within a packet
  localparam logic [IDX_W-1:0] IDX_LEAD       = 4'd0;
  localparam logic [IDX_W-1:0] IDX_SECOND     = 4'd1;
  localparam logic [IDX_W-1:0] IDX_CODE       = 4'd2;
  localparam logic [IDX_W-1:0] IDX_SIZE_FIELD = 4'd4;
  localparam logic [IDX_W-1:0] IDX_MAX        = 4'd15;

  localparam logic [LEN_W-1:0] FLAC_MIN_LEN      = 5'd3;
  localparam logic [LEN_W-1:0] FLAC_EXPL_MIN_LEN = 5'd5;
  localparam logic [LEN_W-1:0] OPUS_ARB_MIN_LEN  = 5'd2;

  localparam logic [3:0] FLAC_CODE_RESERVED = 4'd0;
  localparam logic [3:0] FLAC_CODE_EXPL8    = 4'd6;
  localparam logic [3:0] FLAC_CODE_EXPL16   = 4'd7;

  localparam logic [1:0] OPUS_FC_ONE    = 2'd0;
  localparam logic [1:0] OPUS_FC_TWO_EQ = 2'd1;
  localparam logic [1:0] OPUS_FC_TWO    = 2'd2;

  localparam logic [OPUS_D_W-1:0] OPUS_MAX_DUR = 18'd5760;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_SYNC  = 3'd1,
    ST_RESERVED = 3'd2,
    ST_BAD_DUR  = 3'd3,
    ST_SHORT    = 3'd4
  } status_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_CODEC_MODE     = 2'd0,
    CFG_PRE_SKIP       = 2'd1,
    CFG_GRANULE_OFFSET = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] second;
    logic [3:0]        size_code;
    logic [IDX_W-1:0]  size_pos;
    logic [BYTE_W-1:0] size_high;
    logic [BYTE_W-1:0] size_low;
    logic [LEN_W-1:0]  len;
    logic              last;
    logic              start;
    logic              eos;
    logic [TS_W-1:0]   gpos;
  } hdr_t;

  typedef struct packed {
    logic [DUR_W-1:0] dur;
    logic [TS_W-1:0]  pts;
    status_e          status;
  } res_t;

  function automatic logic [2:0] utf8_len(input logic [BYTE_W-1:0] b);
    logic [2:0] r;
    if (b[7] == 1'b0)             r = 3'd1;
    else if (b[7:5] == 3'b110)    r = 3'd2;
    else if (b[7:4] == 4'b1110)   r = 3'd3;
    else if (b[7:3] == 5'b11110)  r = 3'd4;
    else if (b[7:2] == 6'b111110) r = 3'd5;
    else if (b[7:1] == 7'b1111110) r = 3'd6;
    else if (b == 8'hFE)          r = 3'd7;
    else                          r = 3'd0;
    return r;
  endfunction

  function automatic logic [OPUS_LEN_W-1:0] opus_frame_len(input logic [4:0] toc);
    logic [OPUS_LEN_W-1:0] r;
    if (toc < 5'd12) begin
      case (toc[1:0])
        2'd0:    r = 12'd480;
        2'd1:    r = 12'd960;
        2'd2:    r = 12'd1920;
        default: r = 12'd2880;
      endcase
    end else if (toc < 5'd16) begin
      r = toc[0] ? 12'd960 : 12'd480;
    end else begin
      case (toc[1:0])
        2'd0:    r = 12'd120;
        2'd1:    r = 12'd240;
        2'd2:    r = 12'd480;
        default: r = 12'd960;
      endcase
    end
    return r;
  endfunction

  function automatic logic [FLAC_LEN_W-1:0] flac_block_len(input logic [3:0] code);
    logic [FLAC_LEN_W-1:0] r;
    case (code)
      4'd1:    r = 16'd192;
      4'd2:    r = 16'd576;
      4'd3:    r = 16'd1152;
      4'd4:    r = 16'd2304;
      4'd5:    r = 16'd4608;
      4'd8:    r = 16'd256;
      4'd9:    r = 16'd512;
      4'd10:   r = 16'd1024;
      4'd11:   r = 16'd2048;
      4'd12:   r = 16'd4096;
      4'd13:   r = 16'd8192;
      4'd14:   r = 16'd16384;
      4'd15:   r = 16'd32768;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/afdt_if.sv
interface afdt_in_if;
  logic                           valid;
  logic                           ready;
  logic [afdt_pkg::BYTE_W-1:0]    pkt_byte;
  logic                           last_byte;
  logic                           stream_start;
  logic                           end_of_stream;
  logic [afdt_pkg::TS_W-1:0]      granule_pos;

  modport source (output valid, pkt_byte, last_byte, stream_start, end_of_stream, granule_pos,
                  input ready);
  modport sink (input valid, pkt_byte, last_byte, stream_start, end_of_stream, granule_pos,
                output ready);
endinterface

interface afdt_out_if;
  logic                           valid;
  logic                           ready;
  logic [afdt_pkg::DUR_W-1:0]     frame_duration;
  logic [afdt_pkg::TS_W-1:0]      frame_pts;
  logic [afdt_pkg::STAT_W-1:0]    status;

  modport source (output valid, frame_duration, frame_pts, status, input ready);
  modport sink (input valid, frame_duration, frame_pts, status, output ready);
endinterface

interface afdt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [afdt_pkg::CIDX_W-1:0]    index;
  logic [afdt_pkg::TS_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/audio_frame_duration_tracker_top.sv
// channel  | dir | payload                                                  | handshake
// pkt_i    | in  | pkt_byte, last_byte, stream_start, end_of_stream,        | valid/ready
//          |     | granule_pos                                              |
// res_o    | out | frame_duration, frame_pts, status (one per packet)       | valid/ready
// cfg_i    | in  | index, data (0 codec_mode, 1 pre_skip, 2 granule_offset) | valid/ready
//
// One packet byte per cycle while the output queue has room. The result word of a packet is registered in the
// output queue in the cycle after its final byte is taken.
// The two-entry output queue sets the stall: bytes are taken while it has room.
// Reset clears the timestamp, the header capture state, the configuration and the queue pointers.
// cfg_i is always ready; write it only while no packet is in progress.
module audio_frame_duration_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  afdt_in_if.sink     pkt_i,
  afdt_out_if.source  res_o,
  afdt_cfg_if.sink    cfg_i
);
  import afdt_pkg::*;

  logic accept;
  logic room;
  hdr_t hdr;
  res_t res;

  assign pkt_i.ready = room;
  assign accept      = pkt_i.valid && room;

  afdt_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (pkt_i.pkt_byte),
    .last_i   (pkt_i.last_byte),
    .start_i  (pkt_i.stream_start),
    .eos_i    (pkt_i.end_of_stream),
    .gpos_i   (pkt_i.granule_pos),
    .hdr_o    (hdr)
  );

  afdt_dur u_dur (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .hdr_i    (hdr),
    .cfg      (cfg_i),
    .res_o    (res)
  );

  afdt_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept && hdr.last),
    .data_i (res),
    .room_o (room),
    .res    (res_o)
  );

endmodule

// File: rtl/afdt_parse.sv
module afdt_parse (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [afdt_pkg::BYTE_W-1:0] byte_i,
  input  logic                        last_i,
  input  logic                        start_i,
  input  logic                        eos_i,
  input  logic [afdt_pkg::TS_W-1:0]   gpos_i,
  output afdt_pkg::hdr_t              hdr_o
);
  import afdt_pkg::*;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [BYTE_W-1:0] lead_q, lead_d;
  logic [BYTE_W-1:0] second_q, second_d;
  logic [3:0]        code_q, code_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [BYTE_W-1:0] high_q, high_d;
  logic [BYTE_W-1:0] low_q, low_d;

  always_comb begin
    lead_d   = lead_q;
    second_d = second_q;
    code_d   = code_q;
    pos_d    = pos_q;
    high_d   = high_q;
    low_d    = low_q;
    case (idx_q)
      IDX_LEAD: begin
        lead_d = byte_i;
        pos_d  = '0;
      end
      IDX_SECOND: begin
        second_d = byte_i;
      end
      IDX_CODE: begin
        code_d = byte_i[7:4];
      end
      IDX_SIZE_FIELD: begin
        pos_d = IDX_SIZE_FIELD + {1'b0, utf8_len(byte_i)};
      end
      default: begin
      end
    endcase
    if (idx_q >= IDX_SIZE_FIELD && idx_q < IDX_MAX) begin
      if (idx_q == pos_d) begin
        high_d = byte_i;
      end else if ({1'b0, idx_q} == {1'b0, pos_d} + 5'd1) begin
        low_d = byte_i;
      end
    end
    if (last_i) begin
      idx_d = '0;
    end else if (idx_q == IDX_MAX) begin
      idx_d = IDX_MAX;
    end else begin
      idx_d = idx_q + 4'd1;
    end
  end

  always_comb begin
    hdr_o.lead      = lead_d;
    hdr_o.second    = second_d;
    hdr_o.size_code = code_d;
    hdr_o.size_pos  = pos_d;
    hdr_o.size_high = high_d;
    hdr_o.size_low  = low_d;
    hdr_o.len       = {1'b0, idx_q} + 5'd1;
    hdr_o.last      = last_i;
    hdr_o.start     = (idx_q == IDX_LEAD) && start_i;
    hdr_o.eos       = eos_i;
    hdr_o.gpos      = gpos_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      lead_q   <= '0;
      second_q <= '0;
      code_q   <= '0;
      pos_q    <= '0;
      high_q   <= '0;
      low_q    <= '0;
    end else if (accept_i) begin
      idx_q    <= idx_d;
      lead_q   <= lead_d;
      second_q <= second_d;
      code_q   <= code_d;
      pos_q    <= pos_d;
      high_q   <= high_d;
      low_q    <= low_d;
    end
  end

endmodule

// File: rtl/afdt_dur.sv
module afdt_dur (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  afdt_pkg::hdr_t hdr_i,
  afdt_cfg_if.sink       cfg,
  output afdt_pkg::res_t res_o
);
  import afdt_pkg::*;

  logic               mode_q, mode_d;
  logic [PSKIP_W-1:0] pskip_q, pskip_d;
  logic [TS_W-1:0]    goff_q, goff_d;
  // reload values for stream start, and play position plus granule offset
  logic [TS_W-1:0]    rl_pp_q, rl_pp_d;
  logic [TS_W-1:0]    rl_anc_q, rl_anc_d;
  logic [TS_W-1:0]    pp_q, pp_d;
  logic [TS_W-1:0]    anc_q, anc_d;

  logic [TS_W-1:0]       pp_eff;
  logic [TS_W-1:0]       anc_eff;
  logic [TS_W-1:0]       gap;
  logic [OPUS_LEN_W-1:0] opus_base;
  logic [OPUS_D_W-1:0]   opus_prod;
  logic [OPUS_D_W-1:0]   opus_d;
  logic [LEN_W-1:0]      need;
  logic [DUR_W-1:0]      dur;
  status_e               st;
  logic                  cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;

  assign pp_eff    = hdr_i.start ? rl_pp_q : pp_q;
  assign anc_eff   = hdr_i.start ? rl_anc_q : anc_q;
  assign gap       = hdr_i.gpos - anc_eff;
  assign opus_base = opus_frame_len(hdr_i.lead[7:3]);
  assign opus_prod = {6'b0, opus_base} * {12'b0, hdr_i.second[5:0]};
  assign need      = {1'b0, hdr_i.size_pos}
                   + ((hdr_i.size_code == FLAC_CODE_EXPL16) ? 5'd2 : 5'd1);

  always_comb begin
    st     = ST_OK;
    dur    = '0;
    opus_d = '0;
    if (!mode_q) begin
      if (hdr_i.lead != FLAC_SYNC) begin
        st = ST_NO_SYNC;
      end else if (hdr_i.len < FLAC_MIN_LEN) begin
        st = ST_SHORT;
      end else if (hdr_i.size_code == FLAC_CODE_RESERVED) begin
        st = ST_RESERVED;
      end else if (hdr_i.size_code == FLAC_CODE_EXPL8
                   || hdr_i.size_code == FLAC_CODE_EXPL16) begin
        if (hdr_i.len < FLAC_EXPL_MIN_LEN || hdr_i.len < need) begin
          st = ST_SHORT;
        end else if (hdr_i.size_code == FLAC_CODE_EXPL8) begin
          dur = {9'b0, hdr_i.size_low} + 17'd1;
        end else begin
          dur = {1'b0, hdr_i.size_high, hdr_i.size_low} + 17'd1;
        end
      end else begin
        dur = {1'b0, flac_block_len(hdr_i.size_code)};
      end
    end else begin
      case (hdr_i.lead[1:0])
        OPUS_FC_ONE: begin
          opus_d = {6'b0, opus_base};
        end
        OPUS_FC_TWO_EQ, OPUS_FC_TWO: begin
          opus_d = {5'b0, opus_base, 1'b0};
        end
        default: begin
          opus_d = opus_prod;
          if (hdr_i.len < OPUS_ARB_MIN_LEN) begin
            st = ST_SHORT;
          end
        end
      endcase
      if (st == ST_OK) begin
        if (opus_d == '0 || opus_d > OPUS_MAX_DUR) begin
          st = ST_BAD_DUR;
        end else begin
          // trim last packet against the granule position
          if (hdr_i.eos && hdr_i.gpos != '1 && gap[TS_W-1:TRIM_W] == '0
              && gap[TRIM_W-1:0] < opus_d[TRIM_W-1:0]) begin
            dur = {4'b0, gap[TRIM_W-1:0]};
          end else begin
            dur = opus_d[DUR_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    res_o.dur    = dur;
    res_o.pts    = pp_eff;
    res_o.status = st;
  end

  always_comb begin
    mode_d   = mode_q;
    pskip_d  = pskip_q;
    goff_d   = goff_q;
    rl_pp_d  = rl_pp_q;
    rl_anc_d = rl_anc_q;
    pp_d     = pp_q;
    anc_d    = anc_q;
    if (accept_i) begin
      if (hdr_i.start) begin
        pp_d  = rl_pp_q;
        anc_d = rl_anc_q;
      end
      if (hdr_i.last && st == ST_OK) begin
        pp_d  = pp_eff + {47'b0, dur};
        anc_d = anc_eff + {47'b0, dur};
      end
    end
    if (cfg_wr) begin
      case (cfg.index)
        CFG_CODEC_MODE: begin
          mode_d = cfg.data[0];
        end
        CFG_PRE_SKIP: begin
          pskip_d  = cfg.data[PSKIP_W-1:0];
          rl_pp_d  = 64'd0 - {48'b0, cfg.data[PSKIP_W-1:0]};
          rl_anc_d = goff_q - {48'b0, cfg.data[PSKIP_W-1:0]};
        end
        CFG_GRANULE_OFFSET: begin
          goff_d   = cfg.data;
          rl_anc_d = cfg.data - {48'b0, pskip_q};
          anc_d    = pp_q + cfg.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      pskip_q  <= '0;
      goff_q   <= '0;
      rl_pp_q  <= '0;
      rl_anc_q <= '0;
      pp_q     <= '0;
      anc_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      pskip_q  <= pskip_d;
      goff_q   <= goff_d;
      rl_pp_q  <= rl_pp_d;
      rl_anc_q <= rl_anc_d;
      pp_q     <= pp_d;
      anc_q    <= anc_d;
    end
  end

endmodule

// File: rtl/afdt_obuf.sv
module afdt_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  afdt_pkg::res_t data_i,
  output logic           room_o,
  afdt_out_if.source     res
);
  import afdt_pkg::*;

  res_t       slot_q [OBUF_DEPTH];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  res_t       head;

  assign room_o = (cnt_q != 2'(OBUF_DEPTH));
  assign pop    = res.valid && res.ready;
  assign head   = slot_q[rd_q];

  assign res.valid          = (cnt_q != 2'd0);
  assign res.frame_duration = head.dur;
  assign res.frame_pts      = head.pts;
  assign res.status         = head.status;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
